// ===== rtl/aho_pkg.sv =====
// Shared types, constants and fixed-point helpers for the RK4 oscillator step.
// Used by aho_flow, the top level and the checker; no dependencies.
package aho_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] wide_t;

  localparam wide_t SAT_MAX = 64'sd2147483647;
  localparam wide_t SAT_MIN = -64'sd2147483648;
  localparam fix_t  FIX_MAX = 32'sh7fffffff;
  localparam fix_t  FIX_MIN = 32'sh80000000;

  // Reciprocal of three: (2^58 + 2) / 3, exact floor for dividends below 2^57.
  localparam int          DIV3_W  = 57;
  localparam int          DIV3_SH = 58;
  localparam int          DIV3_LO = 29;
  localparam logic [56:0] DIV3_M  = 57'h155555555555556;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_INV_MASS = 2'd0,
    REG_SPRING   = 2'd1,
    REG_QUARTIC  = 2'd2,
    REG_STEP     = 2'd3
  } reg_idx_e;

  // Context that travels with an item through the slope stages
  typedef struct packed {
    fix_t  bq;   // base position
    fix_t  bp;   // base momentum
    wide_t aq;   // weighted increment sum, position
    wide_t ap;   // weighted increment sum, momentum
    logic  ovf;
  } ctx_t;

  typedef struct packed {
    logic ovf;
    fix_t val;
  } sat_t;

  // Right shift by s with rounding to nearest, ties toward plus infinity
  function automatic wide_t rnd(wide_t x, int s);
    return (x + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  // Clamp to 32 bits signed
  function automatic sat_t sat32(wide_t x);
    sat_t r;
    if (x > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = FIX_MAX;
    end else if (x < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = FIX_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/aho_flow.sv =====
// One RK4 slope evaluation plus the next stage point, as an 8-stage pipeline.
// Depends on aho_pkg.
module aho_flow import aho_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int POINT_SHIFT   = FRACTION_BITS_DEF + 1,
  parameter int WEIGHT_SHIFT  = 0,
  parameter bit HAS_POINT     = 1'b1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  fix_t pq_i,
  input  fix_t pp_i,
  input  ctx_t ctx_i,
  input  fix_t inv_mass_i,
  input  fix_t spring_i,
  input  fix_t quartic_i,
  input  fix_t step_i,
  output logic vld_o,
  output fix_t pq_o,
  output fix_t pp_o,
  output ctx_t ctx_o
);

  localparam int F = FRACTION_BITS;

  logic [7:0] vld_q;

  ctx_t  ctx1_q, ctx2_q, ctx3_q, ctx4_q, ctx5_q, ctx6_q, ctx7_q, ctx8_q;
  fix_t  yq1_q, yq2_q;
  wide_t m_dq1_q, m_qq1_q, m_kq1_q;
  fix_t  dq2_q, q2_2_q, dq3_q, dq4_q, q3_4_q, dp6_q;
  wide_t kq2_q, kq3_q, kq4_q, kq5_q;
  wide_t m_q3_3_q, m_lq5_q, m_adq5_q, m_adp7_q;
  fix_t  ptq6_q, ptq7_q, ptq8_q, ptp8_q;

  sat_t  s_dq, s_q2, s_q3, s_dp, s_pq, s_pp;
  ctx_t  ctx2_d, ctx4_d, ctx6_d, ctx8_d;

  // Rounding and clamping between the product registers
  always_comb begin
    s_dq = sat32(rnd(m_dq1_q, F));
    s_q2 = sat32(rnd(m_qq1_q, F));
    s_q3 = sat32(rnd(m_q3_3_q, F));
    s_dp = sat32(-(kq5_q + rnd(m_lq5_q, F)));
    s_pq = sat32(wide_t'(ctx5_q.bq) + rnd(m_adq5_q, POINT_SHIFT));
    s_pp = sat32(wide_t'(ctx7_q.bp) + rnd(m_adp7_q, POINT_SHIFT));

    ctx2_d     = ctx1_q;
    ctx2_d.ovf = ctx1_q.ovf | s_dq.ovf | s_q2.ovf;
    ctx4_d     = ctx3_q;
    ctx4_d.ovf = ctx3_q.ovf | s_q3.ovf;
    ctx6_d     = ctx5_q;
    ctx6_d.aq  = ctx5_q.aq + (rnd(m_adq5_q, F) <<< WEIGHT_SHIFT);
    ctx6_d.ovf = ctx5_q.ovf | s_dp.ovf | (HAS_POINT & s_pq.ovf);
    ctx8_d     = ctx7_q;
    ctx8_d.ap  = ctx7_q.ap + (rnd(m_adp7_q, F) <<< WEIGHT_SHIFT);
    ctx8_d.ovf = ctx7_q.ovf | (HAS_POINT & s_pp.ovf);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], vld_i};
    end
  end

  // Data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // products of the point
      ctx1_q   <= ctx_i;
      yq1_q    <= pq_i;
      m_dq1_q  <= wide_t'(pp_i) * wide_t'(inv_mass_i);
      m_qq1_q  <= wide_t'(pq_i) * wide_t'(pq_i);
      m_kq1_q  <= wide_t'(spring_i) * wide_t'(pq_i);
      // q^2, dq, k q
      ctx2_q   <= ctx2_d;
      yq2_q    <= yq1_q;
      dq2_q    <= s_dq.val;
      q2_2_q   <= s_q2.val;
      kq2_q    <= rnd(m_kq1_q, F);
      // q^3 product
      ctx3_q   <= ctx2_q;
      dq3_q    <= dq2_q;
      kq3_q    <= kq2_q;
      m_q3_3_q <= wide_t'(q2_2_q) * wide_t'(yq2_q);
      // q^3
      ctx4_q   <= ctx4_d;
      dq4_q    <= dq3_q;
      kq4_q    <= kq3_q;
      q3_4_q   <= s_q3.val;
      // lambda q^3 and dt dq
      ctx5_q   <= ctx4_q;
      kq5_q    <= kq4_q;
      m_lq5_q  <= wide_t'(quartic_i) * wide_t'(q3_4_q);
      m_adq5_q <= wide_t'(step_i) * wide_t'(dq4_q);
      // dp, next position point
      ctx6_q   <= ctx6_d;
      dp6_q    <= s_dp.val;
      ptq6_q   <= s_pq.val;
      // dt dp
      ctx7_q   <= ctx6_q;
      ptq7_q   <= ptq6_q;
      m_adp7_q <= wide_t'(step_i) * wide_t'(dp6_q);
      // next momentum point
      ctx8_q   <= ctx8_d;
      ptq8_q   <= ptq7_q;
      ptp8_q   <= s_pp.val;
    end
  end

  assign vld_o = vld_q[7];
  assign pq_o  = ptq8_q;
  assign pp_o  = ptp8_q;
  assign ctx_o = ctx8_q;

endmodule

// ===== rtl/anharmonic_oscillator_rk4_step_top.sv =====
// Throughput: one beat per cycle unless a result beat is held; four 8-stage slope
// pipelines, then a 5-stage divide-by-six and update, then a 6-stage energy pipeline.
// A stalled result beat (valid output with out_stall_i) holds the whole pipeline in place.
// Reset clears valid bits and loads the register defaults; data needs none.
module anharmonic_oscillator_rk4_step_top import aho_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fix_t        position_i,
  input  fix_t        momentum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fix_t        next_position_o,
  output fix_t        next_momentum_o,
  output fix_t        energy_o,
  output logic        overflow_o
);

  localparam int F = FRACTION_BITS;

  // Configuration registers
  logic [30:0] inv_q;
  fix_t        spring_q, quartic_q, step_q, inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= 31'd65536;
      spring_q  <= 32'sd65536;
      quartic_q <= '0;
      step_q    <= 32'sd655;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_INV_MASS: inv_q     <= cfg_wdata_i[30:0];
        REG_SPRING:   spring_q  <= cfg_wdata_i;
        REG_QUARTIC:  quartic_q <= cfg_wdata_i;
        REG_STEP:     step_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign inv = {1'b0, inv_q};

  // Global advance: everything moves unless a held result blocks it
  logic en;
  logic [10:0] vld_q;
  assign en         = !(vld_q[10] && out_stall_i);
  assign in_stall_o = !en;

  // Slope pipelines k1..k4
  logic v1, v2, v3, v4;
  fix_t pq1, pp1, pq2, pp2, pq3, pp3, pq4u, pp4u;
  ctx_t c0, c1, c2, c3, c4;

  always_comb begin
    c0.bq  = position_i;
    c0.bp  = momentum_i;
    c0.aq  = '0;
    c0.ap  = '0;
    c0.ovf = 1'b0;
  end

  aho_flow #(.FRACTION_BITS(F), .POINT_SHIFT(F + 1), .WEIGHT_SHIFT(0), .HAS_POINT(1'b1))
  u_k1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i && en),
    .pq_i(position_i), .pp_i(momentum_i), .ctx_i(c0),
    .inv_mass_i(inv), .spring_i(spring_q), .quartic_i(quartic_q), .step_i(step_q),
    .vld_o(v1), .pq_o(pq1), .pp_o(pp1), .ctx_o(c1)
  );

  aho_flow #(.FRACTION_BITS(F), .POINT_SHIFT(F + 1), .WEIGHT_SHIFT(1), .HAS_POINT(1'b1))
  u_k2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v1),
    .pq_i(pq1), .pp_i(pp1), .ctx_i(c1),
    .inv_mass_i(inv), .spring_i(spring_q), .quartic_i(quartic_q), .step_i(step_q),
    .vld_o(v2), .pq_o(pq2), .pp_o(pp2), .ctx_o(c2)
  );

  aho_flow #(.FRACTION_BITS(F), .POINT_SHIFT(F), .WEIGHT_SHIFT(1), .HAS_POINT(1'b1))
  u_k3 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v2),
    .pq_i(pq2), .pp_i(pp2), .ctx_i(c2),
    .inv_mass_i(inv), .spring_i(spring_q), .quartic_i(quartic_q), .step_i(step_q),
    .vld_o(v3), .pq_o(pq3), .pp_o(pp3), .ctx_o(c3)
  );

  // last slope: its stage point is not used and does not flag overflow
  aho_flow #(.FRACTION_BITS(F), .POINT_SHIFT(F), .WEIGHT_SHIFT(0), .HAS_POINT(1'b0))
  u_k4 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v3),
    .pq_i(pq3), .pp_i(pp3), .ctx_i(c3),
    .inv_mass_i(inv), .spring_i(spring_q), .quartic_i(quartic_q), .step_i(step_q),
    .vld_o(v4), .pq_o(pq4u), .pp_o(pp4u), .ctx_o(c4)
  );

  // Valid bits of the update and energy stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[9:0], v4};
    end
  end

  // Divide by six: w = (|sum| + 3) / 2, then floor(w / 3) by reciprocal
  wide_t       mag_q, mag_p;
  logic [57:0] u_q, u_p;
  always_comb begin
    mag_q = c4.aq[63] ? -c4.aq : c4.aq;
    mag_p = c4.ap[63] ? -c4.ap : c4.ap;
    u_q   = mag_q[57:0] + 58'd3;
    u_p   = mag_p[57:0] + 58'd3;
  end

  ctx_t        t1_q, t2_q, t3_q, t4_q;
  logic        nq1_q, np1_q, nq2_q, np2_q, nq3_q, np3_q, nq4_q, np4_q;
  logic [56:0] w_q_q, w_p_q;
  logic [55:0] hh_q_q, hh_p_q, qt_q_q, qt_p_q;
  logic [56:0] hl_q_q, lh_q_q, hl_p_q, lh_p_q;
  logic [57:0] ll_q_q, ll_p_q, ll3_q_q, ll3_p_q, mid_q_q, mid_p_q;
  logic [55:0] hh3_q_q, hh3_p_q;
  logic [113:0] full_q, full_p;

  always_comb begin
    full_q = (114'(hh3_q_q) << DIV3_SH) + (114'(mid_q_q) << DIV3_LO) + 114'(ll3_q_q);
    full_p = (114'(hh3_p_q) << DIV3_SH) + (114'(mid_p_q) << DIV3_LO) + 114'(ll3_p_q);
  end

  // Update and energy
  wide_t inc_q, inc_p;
  sat_t  s_nq, s_np, s_pp, s_qq, s_q4, s_e;
  fix_t  nq5_q, np5_q, nq_e1_q, np_e1_q, pp2_q, qq2_q, qq3_q, q4_4_q;
  logic  ovf5_q, ovf_e1_q, ovf2_q, ovf3_q, ovf4_q, ovf5e_q, ovf6_q;
  wide_t m_pp1_q, m_qq1_q, m_pi3_q, m_kq3_q, m_q43_q;
  wide_t pi4_q, kq4_q, sum5_q, m_lq5_q;
  fix_t  e6_q, nq6_q, np6_q, nq_e2_q, np_e2_q, nq3e_q, np3e_q, nq4e_q, np4e_q;
  fix_t  nq5e_q, np5e_q;

  always_comb begin
    inc_q = nq4_q ? -wide_t'({8'b0, qt_q_q}) : wide_t'({8'b0, qt_q_q});
    inc_p = np4_q ? -wide_t'({8'b0, qt_p_q}) : wide_t'({8'b0, qt_p_q});
    s_nq  = sat32(wide_t'(t4_q.bq) + inc_q);
    s_np  = sat32(wide_t'(t4_q.bp) + inc_p);
    s_pp  = sat32(rnd(m_pp1_q, F));
    s_qq  = sat32(rnd(m_qq1_q, F));
    s_q4  = sat32(rnd(m_q43_q, F));
    s_e   = sat32(sum5_q + rnd(m_lq5_q, F + 2));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // magnitude, sign
      t1_q    <= c4;
      nq1_q   <= c4.aq[63];
      np1_q   <= c4.ap[63];
      w_q_q   <= u_q[57:1];
      w_p_q   <= u_p[57:1];
      // partial products of w times the reciprocal
      t2_q    <= t1_q;
      nq2_q   <= nq1_q;
      np2_q   <= np1_q;
      hh_q_q  <= w_q_q[56:DIV3_LO] * DIV3_M[56:DIV3_LO];
      hl_q_q  <= w_q_q[56:DIV3_LO] * DIV3_M[DIV3_LO-1:0];
      lh_q_q  <= w_q_q[DIV3_LO-1:0] * DIV3_M[56:DIV3_LO];
      ll_q_q  <= w_q_q[DIV3_LO-1:0] * DIV3_M[DIV3_LO-1:0];
      hh_p_q  <= w_p_q[56:DIV3_LO] * DIV3_M[56:DIV3_LO];
      hl_p_q  <= w_p_q[56:DIV3_LO] * DIV3_M[DIV3_LO-1:0];
      lh_p_q  <= w_p_q[DIV3_LO-1:0] * DIV3_M[56:DIV3_LO];
      ll_p_q  <= w_p_q[DIV3_LO-1:0] * DIV3_M[DIV3_LO-1:0];
      // middle terms
      t3_q    <= t2_q;
      nq3_q   <= nq2_q;
      np3_q   <= np2_q;
      hh3_q_q <= hh_q_q;
      hh3_p_q <= hh_p_q;
      ll3_q_q <= ll_q_q;
      ll3_p_q <= ll_p_q;
      mid_q_q <= {1'b0, hl_q_q} + {1'b0, lh_q_q};
      mid_p_q <= {1'b0, hl_p_q} + {1'b0, lh_p_q};
      // quotient
      t4_q    <= t3_q;
      nq4_q   <= nq3_q;
      np4_q   <= np3_q;
      qt_q_q  <= full_q[113:DIV3_SH];
      qt_p_q  <= full_p[113:DIV3_SH];
      // new phase point
      nq5_q   <= s_nq.val;
      np5_q   <= s_np.val;
      ovf5_q  <= t4_q.ovf | s_nq.ovf | s_np.ovf;
      // squares
      nq_e1_q  <= nq5_q;
      np_e1_q  <= np5_q;
      ovf_e1_q <= ovf5_q;
      m_pp1_q  <= wide_t'(np5_q) * wide_t'(np5_q);
      m_qq1_q  <= wide_t'(nq5_q) * wide_t'(nq5_q);
      // p^2, q^2
      nq_e2_q <= nq_e1_q;
      np_e2_q <= np_e1_q;
      pp2_q   <= s_pp.val;
      qq2_q   <= s_qq.val;
      ovf2_q  <= ovf_e1_q | s_pp.ovf | s_qq.ovf;
      // energy products
      nq3e_q  <= nq_e2_q;
      np3e_q  <= np_e2_q;
      ovf3_q  <= ovf2_q;
      qq3_q   <= qq2_q;
      m_pi3_q <= wide_t'(pp2_q) * wide_t'(inv);
      m_kq3_q <= wide_t'(spring_q) * wide_t'(qq2_q);
      m_q43_q <= wide_t'(qq2_q) * wide_t'(qq2_q);
      // kinetic, harmonic, q^4
      nq4e_q  <= nq3e_q;
      np4e_q  <= np3e_q;
      ovf4_q  <= ovf3_q | s_q4.ovf;
      pi4_q   <= rnd(m_pi3_q, F + 1);
      kq4_q   <= rnd(m_kq3_q, F + 1);
      q4_4_q  <= s_q4.val;
      // quartic term
      nq5e_q  <= nq4e_q;
      np5e_q  <= np4e_q;
      ovf5e_q <= ovf4_q;
      sum5_q  <= pi4_q + kq4_q;
      m_lq5_q <= wide_t'(quartic_q) * wide_t'(q4_4_q);
      // output register
      nq6_q   <= nq5e_q;
      np6_q   <= np5e_q;
      e6_q    <= s_e.val;
      ovf6_q  <= ovf5e_q | s_e.ovf;
    end
  end

  assign out_valid_o     = vld_q[10];
  assign next_position_o = nq6_q;
  assign next_momentum_o = np6_q;
  assign energy_o        = e6_q;
  assign overflow_o      = ovf6_q;

endmodule

// ===== rtl/aho_checker.sv =====
// Port-level checks of the RK4 oscillator step, bound to the top level.
// Depends on aho_pkg.
module aho_checker import aho_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_addr_i,
  input logic [31:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input fix_t        position_i,
  input fix_t        momentum_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input fix_t        next_position_o,
  input fix_t        next_momentum_o,
  input fix_t        energy_o,
  input logic        overflow_o
);

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_position_o)
      && $stable(next_momentum_o) && $stable(energy_o) && $stable(overflow_o))
    else $error("result beat changed while stalled");

  // Input is stalled only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A held result always stalls the input
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while the result is held");

endmodule

bind anharmonic_oscillator_rk4_step_top aho_checker u_aho_checker (.*);
